@@ sv/b64u_pkg.sv @@
`timescale 1ns / 1ps
// Package for the base64url decoder: shared types, error codes, sizes and
// the character-to-sextet mapping. No dependencies.
package b64u_pkg;

	// Default depth of the queue between front and back
	localparam int unsigned QueueDepth = 2;

	// Error codes carried in a result transaction
	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_CHAR = 2'd1,
		ERR_LEN  = 2'd2
	} err_t;

	// Classified character as handed from front to back
	typedef struct packed {
		logic       legal;
		logic [5:0] sextet;
		logic       eos;
	} item_t;

	// One decoded result
	typedef struct packed {
		logic [7:0] data_byte;
		err_t       error_code;
		logic       final_result;
	} result_t;

	// Handshake between two internal parts
	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	// Map a character to {legal, sextet}; illegal characters give sextet 0
	function automatic logic [6:0] map_char(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'd0;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
			r = {1'b1, d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
			r = {1'b1, d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
			r = {1'b1, d[5:0]};
		end else if (c == 8'h2B || c == 8'h2D) begin
			r = {1'b1, 6'd62};
		end else if (c == 8'h2F || c == 8'h5F) begin
			r = {1'b1, 6'd63};
		end
		return r;
	endfunction

endpackage

@@ sv/b64u_in_if.sv @@
`timescale 1ns / 1ps
// Character input channel of the base64url decoder.
// Standalone; no package needed.
interface b64u_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_string;

	modport source (output valid, output char_code, output end_of_string, input ready);
	modport sink (input valid, input char_code, input end_of_string, output ready);
endinterface

@@ sv/b64u_out_if.sv @@
`timescale 1ns / 1ps
// Decoded byte output channel of the base64url decoder.
// Standalone; no package needed.
interface b64u_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [1:0] error_code;
	logic       final_result;

	modport source (output valid, output data_byte, output error_code,
		output final_result, input ready);
	modport sink (input valid, input data_byte, input error_code,
		input final_result, output ready);
endinterface

@@ sv/base64url_decoder.sv @@
`timescale 1ns / 1ps
// Top level of the streaming base64url decoder.
// Uses b64u_pkg, b64u_in_if, b64u_out_if, b64u_front, b64u_queue, b64u_back.
//
// Usage:
//   in_ch takes one character per transaction with end_of_string on the
//   last character of a string. out_ch gives zero or one result per
//   character: a decoded byte at group positions 1 to 3, or an error
//   (invalid character, or length mod 4 equal to one) with final_result
//   set. After an error, characters are dropped up to end of string.
//   Throughput is one character per cycle while the receiver does not
//   stall. A result passes the front classification register and the
//   queue, then the back output register presents it; entries waiting
//   ahead in the queue delay it further.
//   When the receiver stalls, the result holds in the output register,
//   the queue fills and then in_ch.ready drops; up to QUEUE_DEPTH + 2
//   characters are held in flight. Reset empties the queue, clears the
//   valid flags and returns the decoder to group position zero.
module base64url_decoder #(
	parameter int unsigned QUEUE_DEPTH = b64u_pkg::QueueDepth
) (
	input  logic  clk,
	input  logic  arst_n,
	b64u_in_if.sink    in_ch,
	b64u_out_if.source out_ch
);

	b64u_pkg::item_t front_item;
	b64u_pkg::item_t q_item;
	b64u_pkg::hs_t   push;
	logic            push_ready;
	logic            q_valid;
	logic            q_ready;

	b64u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.item       (front_item),
		.push       (push),
		.push_ready (push_ready)
	);

	b64u_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (front_item),
		.wr_valid (push.valid),
		.wr_ready (push_ready),
		.rd_item  (q_item),
		.rd_valid (q_valid),
		.rd_ready (q_ready)
	);

	b64u_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (q_item),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.out_ch     (out_ch)
	);

endmodule

@@ sv/b64u_front.sv @@
`timescale 1ns / 1ps
// Front part: accepts characters, classifies them through the alphabet
// table and registers the classified item. Uses b64u_pkg and b64u_in_if.
module b64u_front (
	input  logic              clk,
	input  logic              arst_n,
	b64u_in_if.sink           in_ch,
	output b64u_pkg::item_t   item,
	output b64u_pkg::hs_t     push,
	input  logic              push_ready
);

	logic            v_s1;
	b64u_pkg::item_t item_s1;
	logic [6:0]      map;
	logic            take;

	// Stage may load when empty or when its content moves on
	assign in_ch.ready = !v_s1 || push_ready;
	assign take        = in_ch.valid && in_ch.ready;
	assign map         = b64u_pkg::map_char(in_ch.char_code);

	// Classified-item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.legal  <= map[6];
			item_s1.sextet <= map[5:0];
			item_s1.eos    <= in_ch.end_of_string;
		end
	end

	assign item       = item_s1;
	assign push.valid = v_s1;
	assign push.ready = push_ready;

endmodule

@@ sv/b64u_queue.sv @@
`timescale 1ns / 1ps
// Short FIFO of classified items between front and back.
// Uses b64u_pkg for the item type.
module b64u_queue #(
	parameter int unsigned DEPTH = b64u_pkg::QueueDepth
) (
	input  logic            clk,
	input  logic            arst_n,
	input  b64u_pkg::item_t wr_item,
	input  logic            wr_valid,
	output logic            wr_ready,
	output b64u_pkg::item_t rd_item,
	output logic            rd_valid,
	input  logic            rd_ready
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	b64u_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]   wptr_q;
	logic [AW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            wr;
	logic            rd;

	assign wr_ready = (cnt_q != FullCnt);
	assign rd_valid = (cnt_q != '0);
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;
	assign rd_item  = mem_q[rptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

	// Fill count never passes the depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FullCnt)
		else $error("queue count above depth");

endmodule

@@ sv/b64u_back.sv @@
`timescale 1ns / 1ps
// Back part: group position tracking, byte assembly, error handling and
// the output register. Uses b64u_pkg and b64u_out_if.
module b64u_back (
	input  logic            clk,
	input  logic            arst_n,
	input  b64u_pkg::item_t item,
	input  logic            item_valid,
	output logic            item_ready,
	b64u_out_if.source      out_ch
);

	logic [1:0]        pos_q;
	logic [5:0]        prev_q;
	logic              failed_q;
	logic              ov_q;
	b64u_pkg::result_t res_q;

	logic              pop;
	logic              emit;
	b64u_pkg::result_t res;
	logic [1:0]        pos_d;
	logic [5:0]        prev_d;
	logic              failed_d;

	assign item_ready = !ov_q || out_ch.ready;
	assign pop        = item_valid && item_ready;

	// Next state and result for the item at the head of the queue
	always_comb begin
		emit             = 1'b0;
		res.data_byte    = 8'd0;
		res.error_code   = b64u_pkg::ERR_NONE;
		res.final_result = item.eos;
		pos_d            = pos_q;
		prev_d           = prev_q;
		failed_d         = failed_q;
		if (failed_q) begin
			// dropping until end of string
		end else if (!item.legal) begin
			emit             = 1'b1;
			res.error_code   = b64u_pkg::ERR_CHAR;
			res.final_result = 1'b1;
			failed_d         = 1'b1;
		end else begin
			emit   = 1'b1;
			prev_d = item.sextet;
			unique case (pos_q)
				2'd0: begin
					if (item.eos) begin
						res.error_code   = b64u_pkg::ERR_LEN;
						res.final_result = 1'b1;
					end else begin
						emit = 1'b0;
					end
					pos_d = 2'd1;
				end
				2'd1: begin
					res.data_byte = {prev_q, item.sextet[5:4]};
					pos_d         = 2'd2;
				end
				2'd2: begin
					res.data_byte = {prev_q[3:0], item.sextet[5:2]};
					pos_d         = 2'd3;
				end
				default: begin
					res.data_byte = {prev_q[1:0], item.sextet};
					pos_d         = 2'd0;
				end
			endcase
		end
		// end of string restores the reset state
		if (item.eos) begin
			pos_d    = 2'd0;
			prev_d   = 6'd0;
			failed_d = 1'b0;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 2'd0;
			prev_q   <= 6'd0;
			failed_q <= 1'b0;
		end else if (pop) begin
			pos_q    <= pos_d;
			prev_q   <= prev_d;
			failed_q <= failed_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (item_ready) begin
			ov_q <= pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.data_byte    = res_q.data_byte;
	assign out_ch.error_code   = res_q.error_code;
	assign out_ch.final_result = res_q.final_result;

	// Error results are final and carry a zero byte
	a_err_final: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && res_q.error_code != b64u_pkg::ERR_NONE
		|-> res_q.final_result && res_q.data_byte == 8'd0)
		else $error("error result not final or nonzero byte");

	// End of string returns the state to its reset value
	a_eos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.eos |=> pos_q == 2'd0 && prev_q == 6'd0 && !failed_q)
		else $error("state not cleared after end of string");

	// A stalled result stays in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !out_ch.ready |=> ov_q && $stable(res_q))
		else $error("stalled result changed");

endmodule

@@ tb/base64url_decoder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for base64url_decoder: directed rows, then random strings.
// Depends on b64u_pkg, b64u_in_if, b64u_out_if and the decoder RTL.
module base64url_decoder_tb;

	localparam int ItemTarget = 1750;
	localparam int StallLimit = 2000;
	localparam int NumRows = 26;

	// Results that can be typed in by hand
	localparam b64u_pkg::result_t Zeros       = '{8'h00, b64u_pkg::ERR_NONE, 1'b0};
	localparam b64u_pkg::result_t ZerosLast   = '{8'h00, b64u_pkg::ERR_NONE, 1'b1};
	localparam b64u_pkg::result_t AllOnes     = '{8'hFF, b64u_pkg::ERR_NONE, 1'b0};
	localparam b64u_pkg::result_t AllOnesLast = '{8'hFF, b64u_pkg::ERR_NONE, 1'b1};
	localparam b64u_pkg::result_t CharErr     = '{8'h00, b64u_pkg::ERR_CHAR, 1'b1};
	localparam b64u_pkg::result_t LenErr      = '{8'h00, b64u_pkg::ERR_LEN, 1'b1};

	typedef struct {
		logic [7:0]        ch;
		logic              eos;
		bit                typed;
		b64u_pkg::result_t want;
	} stim_row_t;

	// Directed rows: untyped rows are checked against the predictor
	stim_row_t dir_rows [NumRows] = '{
		'{"A", 1'b1, 1'b1, LenErr},       // single char string: length error
		'{"=", 1'b0, 1'b1, CharErr},      // padding is not accepted
		'{"A", 1'b0, 1'b0, Zeros},        // dropped after error
		'{"Z", 1'b1, 1'b0, Zeros},        // dropped, end of string clears state
		'{"_", 1'b0, 1'b0, Zeros},
		'{"_", 1'b0, 1'b1, AllOnes},
		'{"_", 1'b0, 1'b1, AllOnes},
		'{"_", 1'b1, 1'b1, AllOnesLast},
		'{"A", 1'b0, 1'b0, Zeros},
		'{"A", 1'b0, 1'b1, Zeros},
		'{"A", 1'b0, 1'b1, Zeros},
		'{"A", 1'b1, 1'b1, ZerosLast},
		'{"-", 1'b0, 1'b0, Zeros},        // alternate symbols for 62 and 63
		'{"+", 1'b0, 1'b0, Zeros},
		'{"/", 1'b0, 1'b0, Zeros},
		'{"_", 1'b1, 1'b0, Zeros},
		'{"0", 1'b0, 1'b0, Zeros},
		'{"9", 1'b0, 1'b0, Zeros},
		'{"a", 1'b0, 1'b0, Zeros},
		'{"z", 1'b1, 1'b0, Zeros},
		'{8'hFF, 1'b1, 1'b1, CharErr},    // bad char on last position
		'{8'h00, 1'b0, 1'b1, CharErr},
		'{"a", 1'b1, 1'b0, Zeros},        // dropped
		'{"Q", 1'b0, 1'b0, Zeros},        // bytes before an error stand
		'{"U", 1'b0, 1'b0, Zeros},
		'{"@", 1'b1, 1'b1, CharErr}
	};

	logic clk = 1'b0;
	logic arst_n;

	b64u_in_if  in_ch();
	b64u_out_if out_ch();

	base64url_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Predictor state
	logic [1:0] grp_pos;
	logic [5:0] prev_sextet;
	logic       str_failed;

	b64u_pkg::result_t expected_results [$];
	bit      steady;
	int      n_fail, n_chars, n_live, n_strings, n_results, n_char_errs, n_len_errs;
	int      idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Character to sextet; returns 0 for characters outside the alphabet
	function automatic bit sextet_of(input logic [7:0] ch, output logic [5:0] v);
		logic [7:0] d;
		d = 8'd0;
		v = 6'd0;
		if (ch >= "A" && ch <= "Z") begin
			d = ch - "A";
		end else if (ch >= "a" && ch <= "z") begin
			d = ch - "a" + 8'd26;
		end else if (ch >= "0" && ch <= "9") begin
			d = ch - "0" + 8'd52;
		end else if (ch == "+" || ch == "-") begin
			d = 8'd62;
		end else if (ch == "/" || ch == "_") begin
			d = 8'd63;
		end else begin
			return 1'b0;
		end
		v = d[5:0];
		return 1'b1;
	endfunction

	function automatic logic [7:0] char_of_sextet(input logic [5:0] s, input bit alt);
		if (s < 6'd26)
			return "A" + 8'(s);
		else if (s < 6'd52)
			return "a" + 8'(s - 6'd26);
		else if (s < 6'd62)
			return "0" + 8'(s - 6'd52);
		else if (s == 6'd62)
			return alt ? "-" : "+";
		return alt ? "_" : "/";
	endfunction

	function automatic void clear_decode();
		grp_pos = 2'd0;
		prev_sextet = 6'd0;
		str_failed = 1'b0;
	endfunction

	// Decoder prediction for one character; returns 1 when a result is due
	function automatic bit predict_char(input logic [7:0] ch, input logic eos,
			output b64u_pkg::result_t res);
		logic [5:0] v;
		res = Zeros;
		if (str_failed) begin
			if (eos)
				clear_decode();
			return 1'b0;
		end
		if (!sextet_of(ch, v)) begin
			res = CharErr;
			if (eos)
				clear_decode();
			else
				str_failed = 1'b1;
			return 1'b1;
		end
		case (grp_pos)
			2'd0: begin
				if (eos) begin
					res = LenErr;
					clear_decode();
					return 1'b1;
				end
				prev_sextet = v;
				grp_pos = 2'd1;
				return 1'b0;
			end
			2'd1: res.data_byte = {prev_sextet, v[5:4]};
			2'd2: res.data_byte = {prev_sextet[3:0], v[5:2]};
			2'd3: res.data_byte = {prev_sextet[1:0], v};
		endcase
		grp_pos = grp_pos + 2'd1;
		prev_sextet = v;
		res.final_result = eos;
		if (eos)
			clear_decode();
		return 1'b1;
	endfunction

	task automatic report_fault(input string msg);
		n_fail++;
		if (n_fail <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// Send one character transaction; the expectation is logged on acceptance
	task automatic put_char(input logic [7:0] ch, input logic eos, input bit typed,
			input b64u_pkg::result_t want);
		b64u_pkg::result_t res;
		bit      live;
		if (!steady && $urandom_range(99) < 6) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_code <= ch;
		in_ch.end_of_string <= eos;
		do @(posedge clk); while (!in_ch.ready);
		live = !str_failed;
		if (predict_char(ch, eos, res))
			expected_results.push_back(typed ? want : res);
		n_chars++;
		if (live)
			n_live++;
		if (eos)
			n_strings++;
	endtask

	task automatic hold_until_drained();
		in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver back-pressure
	always @(posedge clk)
		out_ch.ready <= steady || ($urandom_range(99) >= 6);

	// Result checker
	always @(posedge clk) begin
		b64u_pkg::result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (out_ch.error_code == b64u_pkg::ERR_CHAR)
				n_char_errs++;
			if (out_ch.error_code == b64u_pkg::ERR_LEN)
				n_len_errs++;
			if (expected_results.size() == 0) begin
				report_fault($sformatf("unexpected result byte=%02h err=%0d final=%0b",
					out_ch.data_byte, out_ch.error_code, out_ch.final_result));
			end else begin
				want = expected_results.pop_front();
				if (out_ch.data_byte !== want.data_byte
						|| out_ch.error_code !== want.error_code
						|| out_ch.final_result !== want.final_result)
					report_fault($sformatf(
						"result %0d: exp byte=%02h err=%0d final=%0b, got byte=%02h err=%0d final=%0b",
						n_results, want.data_byte, want.error_code, want.final_result,
						out_ch.data_byte, out_ch.error_code, out_ch.final_result));
			end
		end
	end

	// Watchdog: ends the run when neither side moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("Timeout: no transaction for %0d cycles", StallLimit);
			$display("** base64url_decoder: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int         len, shape, bad_at;
		bit         pressed;
		logic [7:0] ch;
		logic [5:0] v;
		pressed = 1'b0;
		steady = 1'b0;
		clear_decode();
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.char_code <= 8'h00;
		in_ch.end_of_string <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		for (int r = 0; r < NumRows; r++)
			put_char(dir_rows[r].ch, dir_rows[r].eos, dir_rows[r].typed, dir_rows[r].want);
		hold_until_drained();

		// Random strings: mostly clean, some with one bad char, some pure noise
		while (n_chars < ItemTarget) begin
			steady = (n_chars >= 700 && n_chars < 1000);
			len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
			shape = $urandom_range(99);
			bad_at = (shape >= 70 && shape < 88) ? $urandom_range(len - 1) : -1;
			for (int i = 0; i < len; i++) begin
				if (shape >= 88) begin
					ch = 8'($urandom_range(255));
				end else if (i == bad_at) begin
					if ($urandom_range(3) == 0)
						ch = "=";
					else
						do ch = 8'($urandom_range(255)); while (sextet_of(ch, v));
				end else begin
					ch = char_of_sextet(6'($urandom_range(63)), 1'($urandom_range(1)));
				end
				put_char(ch, i == len - 1, 1'b0, Zeros);
			end
			if (!pressed && n_chars >= 400) begin
				pressed = 1'b1;
				hold_until_drained();
			end
		end
		steady = 1'b0;
		hold_until_drained();
		repeat (10) @(posedge clk);

		if (expected_results.size() != 0)
			report_fault($sformatf("%0d expected results never arrived",
				expected_results.size()));
		$display("Run covered %0d characters in %0d strings (%0d decoded, rest dropped).",
			n_chars, n_strings, n_live);
		$display("Checked %0d results: %0d bad-character and %0d length errors; %0d faults.",
			n_results, n_char_errs, n_len_errs, n_fail);
		if (n_fail == 0) begin
			$display("** base64url_decoder: PASSED **");
		end else begin
			$display("** base64url_decoder: FAILED **");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/b64u_pkg.sv
sv/b64u_in_if.sv
sv/b64u_out_if.sv
sv/b64u_front.sv
sv/b64u_queue.sv
sv/b64u_back.sv
sv/base64url_decoder.sv
tb/base64url_decoder_tb.sv
